FILE: rtl/core/lri_pkg.sv
// shared types, widths and constants of the linear ramp interpolator
`default_nettype none

package lri_pkg;

  // fixed-point formats
  localparam int FRAC_BITS = 16;
  localparam int VALUE_W   = 32;
  localparam int TIME_W    = 32;
  localparam int SLOPE_W   = 48;
  localparam int ROUND_W   = 16;
  localparam int OP_W      = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAKE_CONTINUOUS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PAST_GOAL = CFG_IDX_W'(1);

  // multiplier: |dt| times one slice of |slope| per pass
  localparam int CHUNK_W     = 16;
  localparam int NUM_CHUNKS  = SLOPE_W / CHUNK_W;
  localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
  localparam int PP_W        = TIME_W + CHUNK_W;
  localparam int ACC_W       = TIME_W + SLOPE_W;
  localparam int SH_W        = ACC_W - FRAC_BITS;

  // product magnitude clamp
  localparam int LIMIT_LOG2 = 40;
  localparam int MAG_W      = LIMIT_LOG2 + 1;
  localparam logic [MAG_W-1:0] PROD_LIMIT = MAG_W'(1) << LIMIT_LOG2;
  localparam int SUM_W      = MAG_W + 2;

  // divider
  localparam int DIV_NUM_W = VALUE_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
  localparam int QX_W      = (DIV_NUM_W > SLOPE_W) ? DIV_NUM_W : SLOPE_W;

  // rounding
  localparam int SR_W = VALUE_W + 1;
  localparam logic [SR_W-1:0] HALF = SR_W'(1) << (FRAC_BITS - 1);

  // saturation bounds
  localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
  localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [ROUND_W-1:0] ROUND_MAX = {1'b0, {(ROUND_W-1){1'b1}}};
  localparam logic [ROUND_W-1:0] ROUND_MIN = {1'b1, {(ROUND_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_SET_MOTION = 2'd0,
    OP_SET_GOAL   = 2'd1,
    OP_SAMPLE     = 2'd2
  } op_t;

  // where a new segment takes its start point from
  typedef enum logic [1:0] {
    SRC_INPUT  = 2'd0,
    SRC_SAMPLE = 2'd1,
    SRC_GOAL   = 2'd2
  } src_t;

  typedef struct packed {
    logic                   capture;
    logic                   prep;
    logic                   mul_pp;
    logic                   mul_acc;
    logic                   sat;
    logic                   sum;
    logic                   load_seg;
    src_t                   src;
    logic                   div_init;
    logic                   div_step;
    logic                   div_end;
    logic                   load_out;
    logic [CHUNK_IDX_W-1:0] chunk;
  } cmd_t;

  typedef struct packed {
    op_t op;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/lri_ifs.sv
// request, response and configuration channel interfaces
`default_nettype none

interface lri_req_if;
  logic                                       valid;
  logic                                       ready;
  logic        [lri_pkg::OP_W-1:0]            operation;
  logic signed [lri_pkg::VALUE_W-1:0]         start_value;
  logic        [lri_pkg::TIME_W-1:0]          start_time;
  logic signed [lri_pkg::VALUE_W-1:0]         goal_value;
  logic        [lri_pkg::TIME_W-1:0]          goal_time;
  logic        [lri_pkg::TIME_W-1:0]          query_time;

  modport source (
    output valid, operation, start_value, start_time, goal_value, goal_time, query_time,
    input  ready
  );
  modport sink (
    input  valid, operation, start_value, start_time, goal_value, goal_time, query_time,
    output ready
  );
endinterface

interface lri_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [lri_pkg::VALUE_W-1:0] sample_value;
  logic signed [lri_pkg::ROUND_W-1:0] sample_rounded;

  modport source (output valid, sample_value, sample_rounded, input ready);
  modport sink (input valid, sample_value, sample_rounded, output ready);
endinterface

interface lri_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lri_pkg::CFG_IDX_W-1:0]       index;
  logic [lri_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lri_dp.sv
// datapath: segment registers, sliced multiplier, restoring divider, output register
`default_nettype none

module lri_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire lri_pkg::cmd_t                       cmd,
  output lri_pkg::status_t                         status,
  input  wire logic                                sample_past_goal,
  input  wire logic        [lri_pkg::OP_W-1:0]     in_operation,
  input  wire logic signed [lri_pkg::VALUE_W-1:0]  in_start_value,
  input  wire logic        [lri_pkg::TIME_W-1:0]   in_start_time,
  input  wire logic signed [lri_pkg::VALUE_W-1:0]  in_goal_value,
  input  wire logic        [lri_pkg::TIME_W-1:0]   in_goal_time,
  input  wire logic        [lri_pkg::TIME_W-1:0]   in_query_time,
  output logic signed      [lri_pkg::VALUE_W-1:0]  out_value,
  output logic signed      [lri_pkg::ROUND_W-1:0]  out_rounded
);

  // request registers
  lri_pkg::op_t                         op_reg;
  logic signed [lri_pkg::VALUE_W-1:0]   sv_reg;
  logic        [lri_pkg::TIME_W-1:0]    st_reg;
  logic signed [lri_pkg::VALUE_W-1:0]   gv_reg;
  logic        [lri_pkg::TIME_W-1:0]    gt_reg;
  logic        [lri_pkg::TIME_W-1:0]    qt_reg;

  // segment
  logic        [lri_pkg::TIME_W-1:0]    seg_start_time;
  logic signed [lri_pkg::VALUE_W-1:0]   seg_start_value;
  logic        [lri_pkg::TIME_W-1:0]    seg_goal_time;
  logic signed [lri_pkg::VALUE_W-1:0]   seg_goal_value;
  logic        [lri_pkg::SLOPE_W-1:0]   seg_slope;

  // multiplier
  logic        [lri_pkg::TIME_W-1:0]    mt;
  logic        [lri_pkg::SLOPE_W-1:0]   ms;
  logic                                 prod_neg;
  logic        [lri_pkg::PP_W-1:0]      pp;
  logic        [lri_pkg::ACC_W-1:0]     acc;
  logic        [lri_pkg::MAG_W-1:0]     mag;
  logic signed [lri_pkg::VALUE_W-1:0]   value_reg;

  // divider
  logic        [lri_pkg::DIV_NUM_W-1:0] num;
  logic        [lri_pkg::TIME_W-1:0]    den;
  logic        [lri_pkg::TIME_W-1:0]    rem;
  logic                                 slope_neg;
  logic                                 slope_zero;

  // combinational
  logic        [lri_pkg::TIME_W:0]      dq;
  logic        [lri_pkg::CHUNK_W-1:0]   ms_chunk;
  logic        [lri_pkg::SH_W-1:0]      sh;
  logic signed [lri_pkg::SUM_W-1:0]     start_ext;
  logic signed [lri_pkg::SUM_W-1:0]     mag_ext;
  logic signed [lri_pkg::SUM_W-1:0]     sum;
  logic                                 sum_ovf;
  logic        [lri_pkg::VALUE_W-1:0]   sat_value;
  logic                                 hold;
  logic        [lri_pkg::VALUE_W:0]     dv;
  logic        [lri_pkg::TIME_W:0]      dts;
  logic        [lri_pkg::VALUE_W-1:0]   dv_abs;
  logic        [lri_pkg::TIME_W-1:0]    dt_abs;
  logic        [lri_pkg::TIME_W:0]      rem_sh;
  logic        [lri_pkg::TIME_W:0]      rem_diff;
  logic                                 rem_ge;
  logic        [lri_pkg::QX_W-1:0]      q_ext;
  logic                                 q_sat;
  logic        [lri_pkg::SLOPE_W-1:0]   slope_new;
  logic        [lri_pkg::SR_W-1:0]      rs;
  logic        [lri_pkg::SR_W-1:0]      rs_abs;
  logic        [lri_pkg::SR_W-1:0]      rq_mag;
  logic        [lri_pkg::SR_W-1:0]      rq;
  logic                                 rq_ovf;
  logic        [lri_pkg::ROUND_W-1:0]   round_value;

  assign status.op = op_reg;

  // sample path
  assign dq       = {1'b0, qt_reg} - {1'b0, seg_start_time};
  assign ms_chunk = ms[lri_pkg::SLOPE_W-1 - int'(cmd.chunk) * lri_pkg::CHUNK_W -:
                       lri_pkg::CHUNK_W];
  assign sh       = acc[lri_pkg::ACC_W-1:lri_pkg::FRAC_BITS];
  assign start_ext = lri_pkg::SUM_W'(seg_start_value);
  assign mag_ext   = lri_pkg::SUM_W'(mag);
  assign sum       = prod_neg ? (start_ext - mag_ext) : (start_ext + mag_ext);
  assign sum_ovf   = !((&sum[lri_pkg::SUM_W-1:lri_pkg::VALUE_W-1]) ||
                       (~|sum[lri_pkg::SUM_W-1:lri_pkg::VALUE_W-1]));
  assign sat_value = sum_ovf ? (sum[lri_pkg::SUM_W-1] ? lri_pkg::VALUE_MIN : lri_pkg::VALUE_MAX)
                             : sum[lri_pkg::VALUE_W-1:0];
  assign hold      = !sample_past_goal && (qt_reg >= seg_goal_time);

  // slope path
  assign dv     = {seg_goal_value[lri_pkg::VALUE_W-1], seg_goal_value} -
                  {seg_start_value[lri_pkg::VALUE_W-1], seg_start_value};
  assign dts    = {1'b0, seg_goal_time} - {1'b0, seg_start_time};
  assign dv_abs = lri_pkg::VALUE_W'(dv[lri_pkg::VALUE_W] ? -dv : dv);
  assign dt_abs = lri_pkg::TIME_W'(dts[lri_pkg::TIME_W] ? -dts : dts);

  assign rem_sh   = {rem, num[lri_pkg::DIV_NUM_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, den};
  assign rem_diff = rem_sh - {1'b0, den};

  assign q_ext     = lri_pkg::QX_W'(num);
  assign q_sat     = |q_ext[lri_pkg::QX_W-1:lri_pkg::SLOPE_W-1];
  assign slope_new = slope_zero ? '0 :
                     slope_neg  ? (q_sat ? lri_pkg::SLOPE_MIN : -q_ext[lri_pkg::SLOPE_W-1:0]) :
                                  (q_sat ? lri_pkg::SLOPE_MAX : q_ext[lri_pkg::SLOPE_W-1:0]);

  // value plus one half, truncated toward zero
  assign rs     = lri_pkg::SR_W'(value_reg) + lri_pkg::HALF;
  assign rs_abs = rs[lri_pkg::SR_W-1] ? -rs : rs;
  assign rq_mag = rs_abs >> lri_pkg::FRAC_BITS;
  assign rq     = rs[lri_pkg::SR_W-1] ? -rq_mag : rq_mag;
  assign rq_ovf = !((&rq[lri_pkg::SR_W-1:lri_pkg::ROUND_W-1]) ||
                    (~|rq[lri_pkg::SR_W-1:lri_pkg::ROUND_W-1]));
  assign round_value = rq_ovf ? (rq[lri_pkg::SR_W-1] ? lri_pkg::ROUND_MIN : lri_pkg::ROUND_MAX)
                              : rq[lri_pkg::ROUND_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_reg <= lri_pkg::op_t'(in_operation);
      sv_reg <= in_start_value;
      st_reg <= in_start_time;
      gv_reg <= in_goal_value;
      gt_reg <= in_goal_time;
      qt_reg <= in_query_time;
    end
    if (cmd.prep) begin
      mt       <= lri_pkg::TIME_W'(dq[lri_pkg::TIME_W] ? -dq : dq);
      ms       <= seg_slope[lri_pkg::SLOPE_W-1] ? -seg_slope : seg_slope;
      prod_neg <= dq[lri_pkg::TIME_W] ^ seg_slope[lri_pkg::SLOPE_W-1];
      acc      <= '0;
    end
    if (cmd.mul_pp) begin
      pp <= mt * ms_chunk;
    end
    if (cmd.mul_acc) begin
      acc <= (acc << lri_pkg::CHUNK_W) + lri_pkg::ACC_W'(pp);
    end
    if (cmd.sat) begin
      mag <= (sh > lri_pkg::SH_W'(lri_pkg::PROD_LIMIT)) ? lri_pkg::PROD_LIMIT
                                                        : sh[lri_pkg::MAG_W-1:0];
    end
    if (cmd.sum) begin
      value_reg <= hold ? seg_goal_value : sat_value;
    end
    if (cmd.div_init) begin
      num        <= lri_pkg::DIV_NUM_W'(dv_abs) << lri_pkg::FRAC_BITS;
      den        <= dt_abs;
      rem        <= '0;
      slope_neg  <= dv[lri_pkg::VALUE_W] ^ dts[lri_pkg::TIME_W];
      slope_zero <= (dts == '0);
    end
    if (cmd.div_step) begin
      rem <= rem_ge ? rem_diff[lri_pkg::TIME_W-1:0] : rem_sh[lri_pkg::TIME_W-1:0];
      num <= {num[lri_pkg::DIV_NUM_W-2:0], rem_ge};
    end
    if (cmd.load_out) begin
      out_value   <= value_reg;
      out_rounded <= round_value;
    end
  end

  // segment state, zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_start_time  <= '0;
      seg_start_value <= '0;
      seg_goal_time   <= '0;
      seg_goal_value  <= '0;
      seg_slope       <= '0;
    end else begin
      if (cmd.load_seg) begin
        case (cmd.src)
          lri_pkg::SRC_INPUT: begin
            seg_start_value <= sv_reg;
            seg_start_time  <= st_reg;
          end
          lri_pkg::SRC_SAMPLE: begin
            seg_start_value <= value_reg;
            seg_start_time  <= qt_reg;
          end
          lri_pkg::SRC_GOAL: begin
            seg_start_value <= seg_goal_value;
            seg_start_time  <= seg_goal_time;
          end
          default: begin
            seg_start_value <= seg_start_value;
            seg_start_time  <= seg_start_time;
          end
        endcase
        seg_goal_value <= gv_reg;
        seg_goal_time  <= gt_reg;
      end
      if (cmd.div_end) begin
        seg_slope <= slope_new;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lri_ctrl.sv
// controller: sequences capture, multiply, divide and result hand-off
`default_nettype none

module lri_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire logic             make_continuous,
  output lri_pkg::cmd_t         cmd,
  input  wire lri_pkg::status_t status
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DECODE   = 12'b0000_0000_0010,
    S_PREP     = 12'b0000_0000_0100,
    S_MUL_PP   = 12'b0000_0000_1000,
    S_MUL_ACC  = 12'b0000_0001_0000,
    S_SAT      = 12'b0000_0010_0000,
    S_SUM      = 12'b0000_0100_0000,
    S_RESULT   = 12'b0000_1000_0000,
    S_LOAD     = 12'b0001_0000_0000,
    S_DIV_INIT = 12'b0010_0000_0000,
    S_DIV_STEP = 12'b0100_0000_0000,
    S_DIV_END  = 12'b1000_0000_0000
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [lri_pkg::CHUNK_IDX_W-1:0] chunk;
  logic [lri_pkg::CHUNK_IDX_W-1:0] chunk_next;
  logic [lri_pkg::DIV_CNT_W-1:0]   cnt;
  logic [lri_pkg::DIV_CNT_W-1:0]   cnt_next;
  logic                            chunk_last;
  logic                            cnt_last;
  logic                            out_free;

  assign in_ready   = (state == S_IDLE);
  assign chunk_last = (chunk == lri_pkg::CHUNK_IDX_W'(lri_pkg::NUM_CHUNKS - 1));
  assign cnt_last   = (cnt == lri_pkg::DIV_CNT_W'(lri_pkg::DIV_NUM_W - 1));
  assign out_free   = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    chunk_next = chunk;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.chunk  = chunk;
    cmd.src    = lri_pkg::SRC_INPUT;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.op)
          lri_pkg::OP_SET_MOTION: state_next = S_LOAD;
          lri_pkg::OP_SET_GOAL:   state_next = make_continuous ? S_PREP : S_LOAD;
          lri_pkg::OP_SAMPLE:     state_next = S_PREP;
          default:                state_next = S_IDLE;
        endcase
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        chunk_next = '0;
        state_next = S_MUL_PP;
      end
      S_MUL_PP: begin
        cmd.mul_pp = 1'b1;
        state_next = S_MUL_ACC;
      end
      S_MUL_ACC: begin
        cmd.mul_acc = 1'b1;
        chunk_next  = chunk + 1'b1;
        state_next  = chunk_last ? S_SAT : S_MUL_PP;
      end
      S_SAT: begin
        cmd.sat    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = (status.op == lri_pkg::OP_SAMPLE) ? S_RESULT : S_LOAD;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_LOAD: begin
        cmd.load_seg = 1'b1;
        if (status.op == lri_pkg::OP_SET_MOTION) begin
          cmd.src = lri_pkg::SRC_INPUT;
        end else if (make_continuous) begin
          cmd.src = lri_pkg::SRC_SAMPLE;
        end else begin
          cmd.src = lri_pkg::SRC_GOAL;
        end
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt_last) begin
          state_next = S_DIV_END;
        end
      end
      S_DIV_END: begin
        cmd.div_end = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chunk     <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      chunk <= chunk_next;
      cnt   <= cnt_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register loaded while a result is pending");

  // a sample request never alters the segment
  a_sample_no_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_seg |-> (status.op != lri_pkg::OP_SAMPLE))
    else $error("segment loaded during a sample request");

  // divider runs its full step count before the slope is written
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_STEP && cnt_last) |=> (state == S_DIV_END))
    else $error("divider did not finish after its last step");

  // an accepted request is decoded next
  a_decode: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == S_DECODE))
    else $error("accepted request not decoded");

endmodule

`default_nettype wire

FILE: rtl/core/linear_ramp_interpolator_top.sv
// top level of the linear ramp interpolator: channels, config registers, control and datapath
// sequence: a sample request is captured, decoded, multiplied slice by slice, clamped and
//   summed, then waits for a free output register; set-motion and plain set-goal load the
//   segment and run the one-bit-a-cycle divider; a continuous set-goal adds the sample path
// throughput: one request at a time; the next is taken as soon as the block is back in idle,
//   even while the last result still sits in the output register
// reset: rst is synchronous, active high; it clears the segment, slope and mode bits to zero
`default_nettype none

module linear_ramp_interpolator_top (
  input wire logic   clk,
  input wire logic   rst,
  lri_req_if.sink    req,
  lri_rsp_if.source  rsp,
  lri_cfg_if.sink    cfg
);

  // mode bits
  logic make_continuous;
  logic sample_past_goal;

  // control/datapath link
  lri_pkg::cmd_t    cmd;
  lri_pkg::status_t status;

  // configuration writes are always taken; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      make_continuous  <= 1'b0;
      sample_past_goal <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        lri_pkg::CFG_MAKE_CONTINUOUS:  make_continuous  <= cfg.data[0];
        lri_pkg::CFG_SAMPLE_PAST_GOAL: sample_past_goal <= cfg.data[0];
        default: begin
          make_continuous  <= make_continuous;
          sample_past_goal <= sample_past_goal;
        end
      endcase
    end
  end

  // sequencer: owns the request/result handshakes and the iteration counters
  lri_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (req.valid),
    .in_ready        (req.ready),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .make_continuous (make_continuous),
    .cmd             (cmd),
    .status          (status)
  );

  // arithmetic: segment state, 3-pass sliced multiplier, restoring divider, result register
  lri_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .sample_past_goal (sample_past_goal),
    .in_operation     (req.operation),
    .in_start_value   (req.start_value),
    .in_start_time    (req.start_time),
    .in_goal_value    (req.goal_value),
    .in_goal_time     (req.goal_time),
    .in_query_time    (req.query_time),
    .out_value        (rsp.sample_value),
    .out_rounded      (rsp.sample_rounded)
  );

endmodule

`default_nettype wire
